// ===== design/feathered_rect_heightmap_splat_defines.svh =====
// assertion macros shared by the heightmap splat rtl
// no dependencies; include by bare file name
`ifndef FEATHERED_RECT_HEIGHTMAP_SPLAT_DEFINES_SVH
`define FEATHERED_RECT_HEIGHTMAP_SPLAT_DEFINES_SVH

// same-cycle implication
`define FRHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("frhs assertion failed");

// next-cycle implication
`define FRHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("frhs assertion failed");

`endif

// ===== design/frhs_pkg.sv =====
// shared constants and types for the heightmap splat block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package frhs_pkg;

    localparam int MAX_COLS   = 64;
    localparam int MAX_ROWS   = 64;
    localparam int DEPTH      = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int DIM_W      = 7;
    localparam int CR_W       = 6;
    localparam int DIV_W      = 22;
    localparam int QUO_W      = 16;

    localparam logic [DIM_W-1:0] MAX_COLS_D = DIM_W'(MAX_COLS);
    localparam logic [DIM_W-1:0] MAX_ROWS_D = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0] MIN_DIM    = DIM_W'(2);

    localparam logic [13:0] RELIEF_HEADING = 14'd6554;
    localparam logic [13:0] RELIEF_GROUND  = 14'd15729;
    localparam logic [16:0] ONE_Q16        = 17'd65536;
    localparam logic [17:0] THREE_Q16      = 18'd196608;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SPLAT = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [2:0] CFG_COLS    = 3'd0;
    localparam logic [2:0] CFG_ROWS    = 3'd1;
    localparam logic [2:0] CFG_FEATH_U = 3'd2;
    localparam logic [2:0] CFG_FEATH_V = 3'd3;
    localparam logic [2:0] CFG_SCALE   = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ===== design/frhs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module frhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/frhs_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle
// depends on frhs_pkg; expects numerator below denominator
`timescale 1ns / 1ps
`default_nettype none

module frhs_div import frhs_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_num,
    input  wire logic [DIV_W-1:0] i_den,
    output t_div_stat             o_stat,
    output logic      [QUO_W-1:0] o_quo
);

    logic                      r_busy;
    logic                      r_done;
    logic [$clog2(QUO_W)-1:0]  r_cnt;
    logic [DIV_W-1:0]          r_rem;
    logic [DIV_W-1:0]          r_den;
    logic [QUO_W-1:0]          r_quo;
    logic [DIV_W:0]            w_rem2;
    logic [DIV_W:0]            w_sub;
    logic                      w_ge;

    always_comb begin
        w_rem2 = {r_rem, 1'b0};
        w_ge   = w_rem2 >= {1'b0, r_den};
        w_sub  = w_rem2 - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sub[DIV_W-1:0] : w_rem2[DIV_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == $clog2(QUO_W)'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

`default_nettype wire

// ===== design/feathered_rect_heightmap_splat.sv =====
// top level: config registers, splat sequencer, shared multiplier, grid memories
// depends on frhs_pkg, frhs_ram, frhs_div and the assertion macro header
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------
//  config   | i_cfg_wr_en                 | i_cfg_index, i_cfg_data
//  input    | i_in_valid / o_in_ready     | i_opcode .. i_region_heading
//  output   | o_out_valid / i_out_ready   | o_height_out, o_material_out
//
// write and unused opcodes load their result on acceptance; read passes S_READ and S_FINISH.
// splat: S_SETUP, S_BOUNDS and S_BASE, then per row a dv divide unless dv saturates, and per
// cell S_TT to S_WB after du saturates or after the 16-step divider runs for du.
// the per-cell steps share the one divider and the single 32x20 multiplier.
// reset is synchronous and active low; grid memories are not cleared.
// a new item is taken only in idle while the output register is free or draining.
`timescale 1ns / 1ps
`default_nettype none
`include "feathered_rect_heightmap_splat_defines.svh"

module feathered_rect_heightmap_splat import frhs_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [1:0]         i_opcode,
    input  wire logic [11:0]        i_cell_index,
    input  wire logic signed [31:0] i_cell_height,
    input  wire logic [7:0]         i_cell_material,
    input  wire logic signed [17:0] i_region_u,
    input  wire logic signed [17:0] i_region_v,
    input  wire logic [16:0]        i_region_width,
    input  wire logic [16:0]        i_region_height,
    input  wire logic               i_region_heading,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_height_out,
    output logic [7:0]              o_material_out
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_SETUP, S_BOUNDS, S_BASE, S_ROW, S_DIV_V, S_CELL,
        S_DIV_U, S_TT, S_PH, S_PL, S_SUM, S_INC, S_WB, S_FINISH
    } t_state;

    t_state r_state;

    // config
    logic [DIM_W-1:0] r_grid_cols, r_grid_rows;
    logic [15:0]      r_feather_u, r_feather_v, r_height_scale;

    // item
    logic signed [17:0] r_ru, r_rv;
    logic [16:0]        r_rw, r_rh;
    logic               r_heading;
    logic               r_is_read;
    logic [2:0]         r_step;

    // per-item precompute
    logic signed [27:0] r_au, r_bu, r_av, r_bv;
    logic [DIV_W-1:0]   r_fu_c, r_fv_c;
    logic [29:0]        r_rh_prod;
    logic [CR_W-1:0]    r_left, r_right, r_top, r_bottom, r_x, r_z;
    logic [ADDR_W-1:0]  r_base, r_addr;

    // per-cell
    logic        r_nu_zero, r_nv_zero;
    logic [16:0] r_du, r_dv;
    logic [32:0] r_tt;
    logic [17:0] r_k;
    logic [34:0] r_ph;
    logic [33:0] r_pl;
    logic [16:0] r_cov;
    logic [22:0] r_inc;

    logic signed [31:0] r_height_out;
    logic [7:0]         r_material_out;
    logic               r_out_valid;

    logic [DIM_W-1:0]   w_ncols, w_nrows;
    logic [CR_W-1:0]    w_c, w_r;
    logic [15:0]        w_fu, w_fv;
    logic [13:0]        w_relief;
    logic signed [19:0] w_ue, w_ve;
    logic signed [31:0] w_ma;
    logic signed [19:0] w_mb;
    logic signed [51:0] w_prod;
    logic signed [27:0] w_nu, w_nv;
    logic               w_u_sat, w_v_sat;
    logic [16:0]        w_d, w_t;
    logic [50:0]        w_sum;
    logic signed [32:0] w_hsum;
    logic signed [31:0] w_hnew;
    logic               w_mat_upd;
    logic               w_accept, w_slot_free, w_load;
    logic               w_div_start;
    logic [DIV_W-1:0]   w_div_num, w_div_den;
    t_div_stat          w_div_stat;
    logic [QUO_W-1:0]   w_div_quo;
    logic               w_h_wr_en, w_m_wr_en, w_rd_en;
    logic [ADDR_W-1:0]  w_wr_addr, w_rd_addr, w_cell_addr;
    logic signed [31:0] w_h_wr_data;
    logic [7:0]         w_m_wr_data;
    logic [31:0]        w_h_rd;
    logic [7:0]         w_m_rd;

    function automatic logic signed [27:0] f_outside(input logic signed [27:0] a0,
                                                     input logic signed [27:0] b0,
                                                     input logic [CR_W-1:0] k);
        logic signed [27:0] kq, da, db, m;
        kq = signed'({6'b0, k, 16'b0});
        da = a0 - kq;
        db = kq - b0;
        m  = '0;
        if (da > m) m = da;
        if (db > m) m = db;
        return m;
    endfunction

    function automatic logic [CR_W-1:0] f_lo(input logic signed [27:0] p,
                                            input logic [CR_W-1:0] lim);
        logic [11:0] q;
        q = p[27:16];
        if (p < 0) return '0;
        if (q > {6'b0, lim}) return lim;
        return q[CR_W-1:0];
    endfunction

    function automatic logic [CR_W-1:0] f_hi(input logic signed [27:0] p,
                                            input logic [CR_W-1:0] lim);
        logic signed [27:0] s;
        logic [11:0]        q;
        s = p + 28'sd65535;
        q = s[27:16];
        if (p <= 0) return '0;
        if (q > {6'b0, lim}) return lim;
        return q[CR_W-1:0];
    endfunction

    // effective grid and feather values
    always_comb begin
        w_ncols = (r_grid_cols < MIN_DIM) ? MIN_DIM :
                  (r_grid_cols > MAX_COLS_D) ? MAX_COLS_D : r_grid_cols;
        w_nrows = (r_grid_rows < MIN_DIM) ? MIN_DIM :
                  (r_grid_rows > MAX_ROWS_D) ? MAX_ROWS_D : r_grid_rows;
        w_c      = CR_W'(w_ncols - 1'b1);
        w_r      = CR_W'(w_nrows - 1'b1);
        w_fu     = (r_feather_u == '0) ? 16'd1 : r_feather_u;
        w_fv     = (r_feather_v == '0) ? 16'd1 : r_feather_v;
        w_relief = r_heading ? RELIEF_HEADING : RELIEF_GROUND;
        w_ue     = 20'(r_ru) + signed'({3'b0, r_rw});
        w_ve     = 20'(r_rv) + signed'({3'b0, r_rh});
    end

    // outside distances, coverage prep, write-back value
    always_comb begin
        w_nu        = f_outside(r_au, r_bu, r_x);
        w_nv        = f_outside(r_av, r_bv, r_z);
        w_u_sat     = w_nu >= signed'({6'b0, r_fu_c});
        w_v_sat     = w_nv >= signed'({6'b0, r_fv_c});
        w_d         = (r_du > r_dv) ? r_du : r_dv;
        w_t         = ONE_Q16 - w_d;
        w_sum       = {r_ph, 16'b0} + {17'b0, r_pl};
        w_hsum      = 33'(signed'(w_h_rd)) + signed'({10'b0, r_inc});
        w_hnew      = (w_hsum > 33'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF : w_hsum[31:0];
        w_mat_upd   = !r_heading && r_nu_zero && r_nv_zero && (w_m_rd <= 8'd1);
        w_cell_addr = r_base + ADDR_W'(r_x);
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_SETUP: begin
                case (r_step)
                    3'd0: begin w_ma = 32'(r_ru); w_mb = signed'({14'b0, w_c}); end
                    3'd1: begin w_ma = 32'(w_ue); w_mb = signed'({14'b0, w_c}); end
                    3'd2: begin w_ma = signed'({16'b0, w_fu}); w_mb = signed'({14'b0, w_c}); end
                    3'd3: begin w_ma = 32'(r_rv); w_mb = signed'({14'b0, w_r}); end
                    3'd4: begin w_ma = 32'(w_ve); w_mb = signed'({14'b0, w_r}); end
                    3'd5: begin w_ma = signed'({16'b0, w_fv}); w_mb = signed'({14'b0, w_r}); end
                    default: begin
                        w_ma = signed'({18'b0, w_relief});
                        w_mb = signed'({4'b0, r_height_scale});
                    end
                endcase
            end
            S_BASE: begin
                w_ma = signed'({26'b0, r_top});
                w_mb = signed'({13'b0, w_ncols});
            end
            S_TT: begin
                w_ma = signed'({15'b0, w_t});
                w_mb = signed'({3'b0, w_t});
            end
            S_PH: begin
                w_ma = signed'({15'b0, r_tt[32:16]});
                w_mb = signed'({2'b0, r_k});
            end
            S_PL: begin
                w_ma = signed'({16'b0, r_tt[15:0]});
                w_mb = signed'({2'b0, r_k});
            end
            S_INC: begin
                w_ma = signed'({2'b0, r_rh_prod});
                w_mb = signed'({3'b0, r_cov});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    // handshake
    always_comb begin
        w_slot_free = !r_out_valid || i_out_ready;
        o_in_ready  = (r_state == S_IDLE) && w_slot_free;
        w_accept    = i_in_valid && o_in_ready;
        w_load      = (w_accept && (i_opcode == OP_WRITE || i_opcode == OP_NONE)) ||
                      ((r_state == S_FINISH) && w_slot_free);
    end

    // divider request
    always_comb begin
        w_div_start = ((r_state == S_ROW) && !w_v_sat) || ((r_state == S_CELL) && !w_u_sat);
        w_div_num   = (r_state == S_ROW) ? w_nv[DIV_W-1:0] : w_nu[DIV_W-1:0];
        w_div_den   = (r_state == S_ROW) ? r_fv_c : r_fu_c;
    end

    // memory ports
    always_comb begin
        w_h_wr_en   = (w_accept && i_opcode == OP_WRITE) || (r_state == S_WB);
        w_m_wr_en   = (w_accept && i_opcode == OP_WRITE) || ((r_state == S_WB) && w_mat_upd);
        w_wr_addr   = (r_state == S_WB) ? r_addr : i_cell_index;
        w_h_wr_data = (r_state == S_WB) ? w_hnew : i_cell_height;
        w_m_wr_data = (r_state == S_WB) ? 8'd1 : i_cell_material;
        w_rd_en     = (w_accept && i_opcode == OP_READ) || (r_state == S_CELL);
        w_rd_addr   = (r_state == S_CELL) ? w_cell_addr : i_cell_index;
    end

    frhs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_stat  (w_div_stat),
        .o_quo   (w_div_quo)
    );

    frhs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_height_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_h_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_h_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_h_rd)
    );

    frhs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_material_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_m_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_m_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_m_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_step         <= '0;
            r_grid_cols    <= MAX_COLS_D;
            r_grid_rows    <= MAX_ROWS_D;
            r_feather_u    <= 16'd2081;
            r_feather_v    <= 16'd2081;
            r_height_scale <= 16'd256;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_COLS:    r_grid_cols    <= i_cfg_data[DIM_W-1:0];
                    CFG_ROWS:    r_grid_rows    <= i_cfg_data[DIM_W-1:0];
                    CFG_FEATH_U: r_feather_u    <= i_cfg_data;
                    CFG_FEATH_V: r_feather_v    <= i_cfg_data;
                    CFG_SCALE:   r_height_scale <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_load) begin
                r_out_valid    <= 1'b1;
                r_height_out   <= (r_state == S_FINISH && r_is_read) ? w_h_rd : '0;
                r_material_out <= (r_state == S_FINISH && r_is_read) ? w_m_rd : '0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ru      <= i_region_u;
                        r_rv      <= i_region_v;
                        r_rw      <= i_region_width;
                        r_rh      <= i_region_height;
                        r_heading <= i_region_heading;
                        r_step    <= '0;
                        r_is_read <= (i_opcode == OP_READ);
                        if (i_opcode == OP_SPLAT) begin
                            r_state <= S_SETUP;
                        end else if (i_opcode == OP_READ) begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_FINISH;
                end
                S_SETUP: begin
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        3'd0: r_au   <= w_prod[27:0];
                        3'd1: r_bu   <= w_prod[27:0];
                        3'd2: r_fu_c <= w_prod[DIV_W-1:0];
                        3'd3: r_av   <= w_prod[27:0];
                        3'd4: r_bv   <= w_prod[27:0];
                        3'd5: r_fv_c <= w_prod[DIV_W-1:0];
                        default: begin
                            r_rh_prod <= w_prod[29:0];
                            r_state   <= S_BOUNDS;
                        end
                    endcase
                end
                S_BOUNDS: begin
                    r_left   <= f_lo(r_au - signed'({6'b0, r_fu_c}), w_c);
                    r_right  <= f_hi(r_bu + signed'({6'b0, r_fu_c}), w_c);
                    r_top    <= f_lo(r_av - signed'({6'b0, r_fv_c}), w_r);
                    r_bottom <= f_hi(r_bv + signed'({6'b0, r_fv_c}), w_r);
                    r_state  <= S_BASE;
                end
                S_BASE: begin
                    r_base  <= w_prod[ADDR_W-1:0];
                    r_z     <= r_top;
                    r_x     <= r_left;
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    r_nv_zero <= (w_nv == '0);
                    if (w_v_sat) begin
                        r_dv    <= ONE_Q16;
                        r_state <= S_CELL;
                    end else begin
                        r_state <= S_DIV_V;
                    end
                end
                S_DIV_V: begin
                    if (w_div_stat.done) begin
                        r_dv    <= {1'b0, w_div_quo};
                        r_state <= S_CELL;
                    end
                end
                S_CELL: begin
                    r_nu_zero <= (w_nu == '0);
                    r_addr    <= w_cell_addr;
                    if (w_u_sat) begin
                        r_du    <= ONE_Q16;
                        r_state <= S_TT;
                    end else begin
                        r_state <= S_DIV_U;
                    end
                end
                S_DIV_U: begin
                    if (w_div_stat.done) begin
                        r_du    <= {1'b0, w_div_quo};
                        r_state <= S_TT;
                    end
                end
                S_TT: begin
                    r_tt    <= w_prod[32:0];
                    r_k     <= THREE_Q16 - {w_t, 1'b0};
                    r_state <= S_PH;
                end
                S_PH: begin
                    r_ph    <= w_prod[34:0];
                    r_state <= S_PL;
                end
                S_PL: begin
                    r_pl    <= w_prod[33:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_cov   <= w_sum[48:32];
                    r_state <= S_INC;
                end
                S_INC: begin
                    r_inc   <= w_prod[46:24];
                    r_state <= S_WB;
                end
                S_WB: begin
                    // step to the next cell of the box, row by row
                    if (r_x == r_right) begin
                        if (r_z == r_bottom) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_z     <= r_z + 1'b1;
                            r_base  <= r_base + ADDR_W'(w_ncols);
                            r_x     <= r_left;
                            r_state <= S_ROW;
                        end
                    end else begin
                        r_x     <= r_x + 1'b1;
                        r_state <= S_CELL;
                    end
                end
                S_FINISH: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_height_out   = r_height_out;
    assign o_material_out = r_material_out;

    `FRHS_ASSERT_IMP(a_div_start_free, i_clk, i_rst_n, w_div_start, !w_div_stat.busy)
    `FRHS_ASSERT_IMP(a_walk_in_box, i_clk, i_rst_n, (r_state == S_WB), ((r_x <= r_right) && (r_z <= r_bottom)))
    `FRHS_ASSERT_NXT(a_out_drains, i_clk, i_rst_n, (o_out_valid && i_out_ready && !w_load), !o_out_valid)

endmodule

`default_nettype wire

// ===== dv/feathered_rect_heightmap_splat_test.sv =====
// self-checking testbench for feathered_rect_heightmap_splat: preload, directed rows, then random items
// checks each result against a given value or its own grid model; depends on frhs_pkg and the rtl
`timescale 1ns / 1ps

module feathered_rect_heightmap_splat_test;
    import frhs_pkg::*;

    localparam longint Q16 = 65536;
    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int PRELOAD = 256;

    typedef struct {
        logic [1:0]  op;
        logic [11:0] idx;
        logic [31:0] hgt;
        logic [7:0]  mat;
        logic signed [17:0] ru;
        logic signed [17:0] rv;
        logic [16:0] rw;
        logic [16:0] rh;
        logic        hd;
    } cmd_t;

    typedef struct {
        logic [31:0] hgt;
        logic [7:0]  mat;
    } cell_t;

    typedef struct {
        cmd_t  cmd;
        logic  known;
        cell_t res;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wr_en = 1'b0;
    logic [2:0] i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [1:0] i_opcode = '0;
    logic [11:0] i_cell_index = '0;
    logic signed [31:0] i_cell_height = '0;
    logic [7:0] i_cell_material = '0;
    logic signed [17:0] i_region_u = '0;
    logic signed [17:0] i_region_v = '0;
    logic [16:0] i_region_width = '0;
    logic [16:0] i_region_height = '0;
    logic i_region_heading = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [31:0] o_height_out;
    logic [7:0] o_material_out;

    feathered_rect_heightmap_splat u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor copy of the grid and registers
    logic [31:0] height_grid [DEPTH];
    logic [7:0]  material_grid [DEPTH];
    bit          written [DEPTH];
    int cols_reg = 64, rows_reg = 64, feath_u_reg = 2081, feath_v_reg = 2081;
    int scale_reg = 256;

    cell_t pending_reads [$];
    int mismatches = 0;
    int cycles = 0;
    int send_idle = 0, recv_stall = 0;
    int hold_req = 0, hold_cnt = 0;
    int big_left = 10;

    function automatic longint dim_clamp(input int v, input int hi);
        if (v < 2) return 2;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void box_of(input cmd_t c, output longint l, output longint r,
                                   output longint t, output longint b);
        longint cc, rr, ru, rv, fu, fv, p;
        cc = dim_clamp(cols_reg, MAX_COLS) - 1;
        rr = dim_clamp(rows_reg, MAX_ROWS) - 1;
        ru = longint'(c.ru);
        rv = longint'(c.rv);
        fu = feath_u_reg ? feath_u_reg : 1;
        fv = feath_v_reg ? feath_v_reg : 1;
        p = (ru - fu) * cc;
        l = (p < 0) ? 0 : p / Q16;
        if (l > cc) l = cc;
        p = (ru + longint'(c.rw) + fu) * cc;
        r = (p <= 0) ? 0 : (p + Q16 - 1) / Q16;
        if (r > cc) r = cc;
        p = (rv - fv) * rr;
        t = (p < 0) ? 0 : p / Q16;
        if (t > rr) t = rr;
        p = (rv + longint'(c.rh) + fv) * rr;
        b = (p <= 0) ? 0 : (p + Q16 - 1) / Q16;
        if (b > rr) b = rr;
    endfunction

    function automatic longint outside_dist(input longint s, input longint sz,
                                            input longint k, input longint n);
        longint a, b, m;
        a = s * n - k * Q16;
        b = k * Q16 - (s + sz) * n;
        m = 0;
        if (a > m) m = a;
        if (b > m) m = b;
        return m;
    endfunction

    function automatic longint feather_frac(input longint num, input longint n, input int f);
        longint q;
        q = (num * Q16) / (n * (f ? f : 1));
        return (q > Q16) ? Q16 : q;
    endfunction

    task automatic splat_grid(input cmd_t c);
        longint l, r, t, b, nc, cc, rr, nu, nv, du, dv, d, tt, cov, inc, h, ix;
        box_of(c, l, r, t, b);
        nc = dim_clamp(cols_reg, MAX_COLS);
        cc = nc - 1;
        rr = dim_clamp(rows_reg, MAX_ROWS) - 1;
        for (longint z = t; z <= b; z++) begin
            for (longint x = l; x <= r; x++) begin
                nu = outside_dist(longint'(c.ru), longint'(c.rw), x, cc);
                nv = outside_dist(longint'(c.rv), longint'(c.rh), z, rr);
                du = feather_frac(nu, cc, feath_u_reg);
                dv = feather_frac(nv, rr, feath_v_reg);
                d = (du > dv) ? du : dv;
                tt = Q16 - d;
                cov = (tt * tt * (3 * Q16 - 2 * tt)) >>> 32;
                inc = ((c.hd ? 64'd6554 : 64'd15729) * scale_reg * cov) >>> 24;
                ix = z * nc + x;
                if (ix >= DEPTH) continue;
                h = longint'($signed(height_grid[ix])) + inc;
                if (h > 64'sd2147483647) h = 64'sd2147483647;
                height_grid[ix] = h[31:0];
                if (!c.hd && nu == 0 && nv == 0 && material_grid[ix] <= 8'd1)
                    material_grid[ix] = 8'd1;
            end
        end
    endtask

    task automatic predict_cell(input cmd_t c, output cell_t res);
        res = '{32'd0, 8'd0};
        case (c.op)
            OP_WRITE: begin
                height_grid[c.idx] = c.hgt;
                material_grid[c.idx] = c.mat;
                written[c.idx] = 1'b1;
            end
            OP_SPLAT: splat_grid(c);
            OP_READ: res = '{height_grid[c.idx], material_grid[c.idx]};
            default: ;
        endcase
    endtask

    // send one item; its expected result is queued at acceptance
    task automatic send_cmd(input cmd_t c, input logic known, input cell_t kres);
        cell_t res;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= c.op;
        i_cell_index <= c.idx;
        i_cell_height <= c.hgt;
        i_cell_material <= c.mat;
        i_region_u <= c.ru;
        i_region_v <= c.rv;
        i_region_width <= c.rw;
        i_region_height <= c.rh;
        i_region_heading <= c.hd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_cell(c, res);
        pending_reads.push_back(known ? kres : res);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] ix, input int val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= ix;
        i_cfg_data <= val[15:0];
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (ix)
            CFG_COLS: cols_reg = val & 'h7f;
            CFG_ROWS: rows_reg = val & 'h7f;
            CFG_FEATH_U: feath_u_reg = val & 'hffff;
            CFG_FEATH_V: feath_v_reg = val & 'hffff;
            default: scale_reg = val & 'hffff;
        endcase
    endtask

    function automatic cmd_t rand_cmd;
        cmd_t c;
        int pick;
        longint l, r, t, b;
        c.op = OP_READ;
        c.idx = $urandom;
        c.hgt = $urandom;
        c.mat = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        c.ru = 18'($urandom_range(0, 75000)) - 18'sd6000;
        c.rv = 18'($urandom_range(0, 75000)) - 18'sd6000;
        c.rw = $urandom_range(0, 9000);
        c.rh = $urandom_range(0, 9000);
        c.hd = $urandom_range(0, 1);
        pick = $urandom_range(0, 99);
        if (pick < 5) c.op = OP_NONE;
        else if (pick < 32) c.op = OP_WRITE;
        else if (pick < 60) c.op = OP_READ;
        else c.op = OP_SPLAT;
        // keep most indexes within the grid in use
        if ($urandom_range(0, 3) != 0)
            c.idx = $urandom_range(0, dim_clamp(cols_reg, 64) * dim_clamp(rows_reg, 64) - 1);
        // reads only of cells that hold a known value
        if (c.op == OP_READ && !written[c.idx])
            c.idx = $urandom_range(0, PRELOAD - 1);
        if (c.op == OP_SPLAT) begin
            if ($urandom_range(0, 9) == 0) begin
                c.ru = $urandom;
                c.rv = $urandom;
                c.rw = $urandom;
                c.rh = $urandom;
            end
            box_of(c, l, r, t, b);
            if ((r - l + 1) * (b - t + 1) > 700) begin
                if (big_left > 0) big_left--;
                else c.op = OP_READ;
            end
        end
        return c;
    endfunction

    // receiver ready with random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        cell_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_reads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item h=%h m=%h",
                    o_height_out, o_material_out);
            end else begin
                want = pending_reads.pop_front();
                if (o_height_out !== want.hgt || o_material_out !== want.mat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected h=%h m=%h, got h=%h m=%h",
                            want.hgt, want.mat, o_height_out, o_material_out);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic row_t mk(input logic [1:0] op, input int idx, input logic [31:0] hgt,
                                input int mat, input int ru, input int rv, input int rw,
                                input int rh, input logic hd, input logic known,
                                input logic [31:0] eh, input int em);
        row_t w;
        w.cmd = '{op, idx[11:0], hgt, mat[7:0], ru[17:0], rv[17:0], rw[16:0], rh[16:0], hd};
        w.known = known;
        w.res = '{eh, em[7:0]};
        return w;
    endfunction

    initial begin
        row_t dir_rows [$];
        cmd_t c;
        int phase_cols [6] = '{16, 2, 8, 64, 13, 100};
        int phase_rows [6] = '{16, 2, 5, 4, 19, 1};
        int phase_fu [6] = '{2081, 1, 0, 65535, 3000, 900};
        int phase_fv [6] = '{2081, 1, 9000, 65535, 700, 65535};
        int phase_sc [6] = '{256, 65535, 4000, 0, 1000, 300};
        int stall_mode [4] = '{0, 0, 85, 27};
        int idle_mode [4] = '{0, 85, 0, 27};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a 16 by 16 grid keeps every splat inside the preloaded cells
        cfg_write(CFG_COLS, 16);
        cfg_write(CFG_ROWS, 16);

        // every cell of the grid in use gets a known value before any read or splat
        for (int k = 0; k < PRELOAD; k++) begin
            c = '{OP_WRITE, k[11:0], $urandom_range(0, 3) == 0 ? 32'h7fff_ff00 + k[7:0] : $urandom,
                  8'($urandom_range(0, 3)), '0, '0, '0, '0, 1'b0};
            send_cmd(c, 1'b0, '{0, 0});
        end

        dir_rows.push_back(mk(OP_WRITE, 0, 32'h7fff_fff0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h7fff_fff0, 0));
        dir_rows.push_back(mk(OP_WRITE, 4095, 32'h8000_0000, 255, 0, 0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(mk(OP_READ, 4095, 0, 0, 0, 0, 0, 0, 0, 1, 32'h8000_0000, 255));
        dir_rows.push_back(mk(OP_NONE, 4095, '1, 255, 0, 0, 0, 0, 1, 1, 0, 0));
        // point region on the corner cell: full coverage, height saturates
        dir_rows.push_back(mk(OP_SPLAT, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h7fff_ffff, 1));
        dir_rows.push_back(mk(OP_WRITE, 17, 0, 2, 0, 0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(mk(OP_WRITE, 18, 32'hffff_0000, 1, 0, 0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(mk(OP_SPLAT, 0, 0, 0, 0, 0, 4000, 4000, 0, 1, 0, 0));
        dir_rows.push_back(mk(OP_READ, 17, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_READ, 18, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_SPLAT, 0, 0, 0, 30000, 30000, 5000, 5000, 1, 1, 0, 0));
        dir_rows.push_back(mk(OP_READ, 7 * 16 + 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_READ, 6 * 16 + 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_SPLAT, 0, 0, 0, -131072, -131072, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(mk(OP_SPLAT, 0, 0, 0, 131071, 131071, 131071, 131071, 0, 1, 0, 0));
        dir_rows.push_back(mk(OP_READ, 255, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_SPLAT, 0, 0, 0, 0, 0, 65536, 65536, 0, 1, 0, 0));
        dir_rows.push_back(mk(OP_READ, 8 * 16 + 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (dir_rows[k]) send_cmd(dir_rows[k].cmd, dir_rows[k].known, dir_rows[k].res);

        for (int p = 0; p < 6; p++) begin
            drain();
            repeat (5) @(posedge i_clk);
            cfg_write(CFG_COLS, phase_cols[p]);
            cfg_write(CFG_ROWS, phase_rows[p]);
            cfg_write(CFG_FEATH_U, phase_fu[p]);
            cfg_write(CFG_FEATH_V, phase_fv[p]);
            cfg_write(CFG_SCALE, phase_sc[p]);
            send_idle = idle_mode[p % 4];
            recv_stall = stall_mode[p % 4];
            if (p == 1) hold_req = 400;
            for (int k = 0; k < 50; k++) begin
                if (k == 25) drain();
                send_cmd(rand_cmd(), 1'b0, '{0, 0});
            end
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_reads.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/frhs_pkg.sv
design/frhs_ram.sv
design/frhs_div.sv
design/feathered_rect_heightmap_splat.sv
dv/feathered_rect_heightmap_splat_test.sv
